// ===== hdl/t4t_pkg.sv =====
// package for the type 4 tag responder: types, codes, command patterns
// and the capability file contents; no dependencies
package t4t_pkg;

  localparam int RECORD_BYTES = 256;
  localparam int RECORD_AW    = $clog2(RECORD_BYTES);
  localparam int WORD_BYTES   = 8;
  localparam int WORD_W       = 8 * WORD_BYTES;
  localparam int LANE_W       = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int CAND_N       = 4;
  localparam int HDR_N        = 5;
  localparam int CC_BYTES     = 15;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  localparam logic [7:0] SW_OK_HI   = 8'h90;
  localparam logic [7:0] SW_OK_LO   = 8'h00;
  localparam logic [7:0] SW_FAIL_HI = 8'h6A;
  localparam logic [7:0] SW_FAIL_LO = 8'h82;

  // candidate order: application select, capability select, data select, read
  localparam int CAND_APP = 0;
  localparam int CAND_CC  = 1;
  localparam int CAND_ND  = 2;
  localparam int CAND_RD  = 3;

  localparam logic [3:0] PAT_LEN [CAND_N] = '{4'd12, 4'd7, 4'd7, 4'd2};

  localparam logic [7:0] PAT [CAND_N][16] = '{
    '{8'h00, 8'hA4, 8'h04, 8'h00, 8'h07, 8'hD2, 8'h76, 8'h00,
      8'h00, 8'h85, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'hA4, 8'h00, 8'h0C, 8'h02, 8'hE1, 8'h03, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'hA4, 8'h00, 8'h0C, 8'h02, 8'hE1, 8'h04, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef enum logic [1:0] {
    PS_READY = 2'd0,
    PS_APP   = 2'd1,
    PS_CC    = 2'd2,
    PS_DATA  = 2'd3
  } proto_state_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_CC   = 2'd1,
    SRC_DATA = 2'd2
  } src_kind_t;

  typedef enum logic [2:0] {
    PK_IDLE     = 3'd0,
    PK_FETCH    = 3'd1,
    PK_PAYLOAD  = 3'd2,
    PK_STAT_HI  = 3'd3,
    PK_STAT_LO  = 3'd4
  } pk_state_t;

  typedef struct packed {
    logic       ok;
    src_kind_t  kind;
    logic [7:0] start;
    logic [7:0] len;
    logic       sent;
  } t4t_job_t;

  function automatic logic [7:0] cc_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h0F;
      4'd2:    b = 8'h20;
      4'd3:    b = 8'h00;
      4'd4:    b = 8'hFF;
      4'd5:    b = 8'h00;
      4'd6:    b = 8'hFF;
      4'd7:    b = 8'h04;
      4'd8:    b = 8'h06;
      4'd9:    b = 8'hE1;
      4'd10:   b = 8'h04;
      4'd11:   b = 8'h00;
      4'd12:   b = 8'hFF;
      4'd13:   b = 8'h00;
      4'd14:   b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/t4t_channels.sv =====
// channel interfaces of the type 4 tag responder: input, result, config
// depends on t4t_pkg
interface t4t_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [t4t_pkg::RECORD_AW-1:0]   record_index;
  logic [7:0]                      data_byte;
  logic                            cmd_last;
  modport source (output valid, action, record_index, data_byte, cmd_last, input ready);
  modport sink   (input valid, action, record_index, data_byte, cmd_last, output ready);
endinterface

interface t4t_out_if;
  logic                        valid;
  logic                        ready;
  logic [t4t_pkg::WORD_W-1:0]  resp_bytes;
  logic [3:0]                  resp_count;
  logic                        resp_last;
  logic                        accepted;
  logic                        record_sent;
  modport source (output valid, resp_bytes, resp_count, resp_last, accepted, record_sent,
                  input ready);
  modport sink   (input valid, resp_bytes, resp_count, resp_last, accepted, record_sent,
                  output ready);
endinterface

interface t4t_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_length;
  modport source (output valid, record_length, input ready);
  modport sink   (input valid, record_length, output ready);
endinterface

// ===== hdl/t4t_matcher.sv =====
// command byte matcher and protocol state; builds one response job per command
// depends on t4t_pkg
module t4t_matcher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              cmd_last,
  input  logic [7:0]        record_length,
  output logic              busy,
  output logic              job_valid,
  output t4t_pkg::t4t_job_t job
);

  logic [t4t_pkg::CAND_N-1:0] flags_r, flags_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic                       decide_r, decide_nxt;
  t4t_pkg::proto_state_t      ps_r, ps_nxt;
  logic [7:0]                 hdr_r [t4t_pkg::HDR_N];
  logic [t4t_pkg::CAND_N-1:0] miss;
  logic [t4t_pkg::CAND_N-1:0] hit;
  logic [15:0]                off;
  logic [16:0]                sum;
  logic [16:0]                bound;

  always_comb begin
    for (int c = 0; c < t4t_pkg::CAND_N; c++) begin
      miss[c] = (cnt_r < t4t_pkg::PAT_LEN[c]) && (t4t_pkg::PAT[c][cnt_r] != data_byte);
      hit[c]  = flags_r[c] && (cnt_r >= t4t_pkg::PAT_LEN[c]);
    end
  end

  assign off   = {hdr_r[2], hdr_r[3]};
  assign sum   = 17'(off) + 17'(hdr_r[4]);
  assign bound = 17'(record_length) + 17'd2;

  always_comb begin
    flags_nxt  = flags_r;
    cnt_nxt    = cnt_r;
    decide_nxt = decide_r;
    ps_nxt     = ps_r;
    job        = '{ok: 1'b0, kind: t4t_pkg::SRC_NONE, start: 8'd0, len: 8'd0, sent: 1'b0};
    if (byte_valid) begin
      flags_nxt  = flags_r & ~miss;
      cnt_nxt    = (cnt_r == 4'hF) ? cnt_r : cnt_r + 4'd1;
      decide_nxt = cmd_last;
    end
    if (decide_r) begin
      flags_nxt  = '1;
      cnt_nxt    = 4'd0;
      decide_nxt = 1'b0;
      if (hit[t4t_pkg::CAND_APP]) begin
        ps_nxt = t4t_pkg::PS_APP;
        job.ok = 1'b1;
      end else if (hit[t4t_pkg::CAND_CC]) begin
        if (ps_r == t4t_pkg::PS_APP) begin
          ps_nxt = t4t_pkg::PS_CC;
          job.ok = 1'b1;
        end
      end else if (hit[t4t_pkg::CAND_ND]) begin
        ps_nxt = t4t_pkg::PS_DATA;
        job.ok = 1'b1;
      end else if (hit[t4t_pkg::CAND_RD]) begin
        if (ps_r == t4t_pkg::PS_CC) begin
          job.ok   = 1'b1;
          job.kind = t4t_pkg::SRC_CC;
          job.len  = 8'(t4t_pkg::CC_BYTES);
        end else if (ps_r == t4t_pkg::PS_DATA && cnt_r >= 4'(t4t_pkg::HDR_N)
                     && sum <= bound) begin
          job.ok    = 1'b1;
          job.kind  = t4t_pkg::SRC_DATA;
          job.start = off[7:0];
          job.len   = hdr_r[4];
          job.sent  = (sum == bound);
        end
      end
      if (!job.ok) begin
        ps_nxt = t4t_pkg::PS_READY;
      end
    end
  end

  assign busy      = decide_r;
  assign job_valid = decide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '1;
      cnt_r    <= 4'd0;
      decide_r <= 1'b0;
      ps_r     <= t4t_pkg::PS_READY;
    end else begin
      flags_r  <= flags_nxt;
      cnt_r    <= cnt_nxt;
      decide_r <= decide_nxt;
      ps_r     <= ps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && cnt_r < 4'(t4t_pkg::HDR_N)) begin
      hdr_r[cnt_r[2:0]] <= data_byte;
    end
  end

endmodule

// ===== hdl/t4t_packer.sv =====
// response sequencer: record store, byte source select and word packing
// into the result register; depends on t4t_pkg and t4t_channels
module t4t_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  t4t_pkg::t4t_job_t             job,
  input  logic [7:0]                    record_length,
  input  logic                          wr_en,
  input  logic [t4t_pkg::RECORD_AW-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  output logic                          idle,
  t4t_out_if.source                     out_ch
);

  t4t_pkg::pk_state_t            state_r, state_nxt;
  t4t_pkg::src_kind_t            kind_r, kind_nxt;
  logic                          ok_r, ok_nxt;
  logic                          sent_r, sent_nxt;
  logic [7:0]                    ptr_r, ptr_nxt;
  logic [7:0]                    remain_r, remain_nxt;
  logic [t4t_pkg::WORD_W-1:0]    word_r, word_nxt;
  logic [t4t_pkg::LANE_W-1:0]    cnt_r, cnt_nxt;

  logic                          o_valid_r, o_valid_nxt;
  logic [t4t_pkg::WORD_W-1:0]    o_bytes_r, o_bytes_nxt;
  logic [3:0]                    o_count_r, o_count_nxt;
  logic                          o_last_r, o_last_nxt;
  logic                          o_ok_r, o_ok_nxt;
  logic                          o_sent_r, o_sent_nxt;

  logic [7:0]                    mem [t4t_pkg::RECORD_BYTES];
  logic [7:0]                    rd_q;
  logic [7:0]                    cur_byte;
  logic [t4t_pkg::WORD_W-1:0]    word_ins;
  logic                          placing, fin, need_push, slot_free, advance;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[t4t_pkg::RECORD_AW'(ptr_r - 8'd2)];
  end

  always_comb begin
    case (state_r)
      t4t_pkg::PK_PAYLOAD: begin
        if (kind_r == t4t_pkg::SRC_CC) begin
          cur_byte = t4t_pkg::cc_byte(ptr_r[3:0]);
        end else if (ptr_r == 8'd0) begin
          cur_byte = 8'd0;
        end else if (ptr_r == 8'd1) begin
          cur_byte = record_length;
        end else begin
          cur_byte = rd_q;
        end
      end
      t4t_pkg::PK_STAT_HI: cur_byte = ok_r ? t4t_pkg::SW_OK_HI : t4t_pkg::SW_FAIL_HI;
      t4t_pkg::PK_STAT_LO: cur_byte = ok_r ? t4t_pkg::SW_OK_LO : t4t_pkg::SW_FAIL_LO;
      default:             cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    word_ins = word_r;
    for (int i = 0; i < t4t_pkg::WORD_BYTES; i++) begin
      if (cnt_r == t4t_pkg::LANE_W'(i)) begin
        word_ins[8*(t4t_pkg::WORD_BYTES-1-i) +: 8] = cur_byte;
      end
    end
  end

  assign placing   = (state_r == t4t_pkg::PK_PAYLOAD) || (state_r == t4t_pkg::PK_STAT_HI)
                     || (state_r == t4t_pkg::PK_STAT_LO);
  assign fin       = (state_r == t4t_pkg::PK_STAT_LO);
  assign need_push = placing
                     && (cnt_r == t4t_pkg::LANE_W'(t4t_pkg::WORD_BYTES - 1) || fin);
  assign slot_free = !o_valid_r || out_ch.ready;
  assign advance   = placing && (!need_push || slot_free);
  assign idle      = (state_r == t4t_pkg::PK_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      t4t_pkg::PK_IDLE: begin
        if (job_valid) begin
          state_nxt = (job.len == 8'd0) ? t4t_pkg::PK_STAT_HI : t4t_pkg::PK_FETCH;
        end
      end
      t4t_pkg::PK_FETCH: state_nxt = t4t_pkg::PK_PAYLOAD;
      t4t_pkg::PK_PAYLOAD: begin
        if (advance) begin
          state_nxt = (remain_r == 8'd1) ? t4t_pkg::PK_STAT_HI : t4t_pkg::PK_FETCH;
        end
      end
      t4t_pkg::PK_STAT_HI: begin
        if (advance) begin
          state_nxt = t4t_pkg::PK_STAT_LO;
        end
      end
      t4t_pkg::PK_STAT_LO: begin
        if (advance) begin
          state_nxt = t4t_pkg::PK_IDLE;
        end
      end
      default: state_nxt = t4t_pkg::PK_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    kind_nxt    = kind_r;
    ok_nxt      = ok_r;
    sent_nxt    = sent_r;
    ptr_nxt     = ptr_r;
    remain_nxt  = remain_r;
    word_nxt    = word_r;
    cnt_nxt     = cnt_r;
    o_bytes_nxt = o_bytes_r;
    o_count_nxt = o_count_r;
    o_last_nxt  = o_last_r;
    o_ok_nxt    = o_ok_r;
    o_sent_nxt  = o_sent_r;
    o_valid_nxt = out_ch.ready ? 1'b0 : o_valid_r;
    if (state_r == t4t_pkg::PK_IDLE && job_valid) begin
      kind_nxt   = job.kind;
      ok_nxt     = job.ok;
      sent_nxt   = job.sent;
      ptr_nxt    = job.start;
      remain_nxt = job.len;
      word_nxt   = '0;
      cnt_nxt    = '0;
    end
    if (advance) begin
      if (state_r == t4t_pkg::PK_PAYLOAD) begin
        ptr_nxt    = ptr_r + 8'd1;
        remain_nxt = remain_r - 8'd1;
      end
      if (need_push) begin
        word_nxt    = '0;
        cnt_nxt     = '0;
        o_valid_nxt = 1'b1;
        o_bytes_nxt = word_ins;
        o_count_nxt = 4'(cnt_r) + 4'd1;
        o_last_nxt  = fin;
        o_ok_nxt    = ok_r;
        o_sent_nxt  = fin && sent_r;
      end else begin
        word_nxt = word_ins;
        cnt_nxt  = cnt_r + t4t_pkg::LANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= t4t_pkg::PK_IDLE;
      o_valid_r <= 1'b0;
      word_r    <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
      word_r    <= word_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    ok_r      <= ok_nxt;
    sent_r    <= sent_nxt;
    ptr_r     <= ptr_nxt;
    remain_r  <= remain_nxt;
    o_bytes_r <= o_bytes_nxt;
    o_count_r <= o_count_nxt;
    o_last_r  <= o_last_nxt;
    o_ok_r    <= o_ok_nxt;
    o_sent_r  <= o_sent_nxt;
  end

  assign out_ch.valid       = o_valid_r;
  assign out_ch.resp_bytes  = o_bytes_r;
  assign out_ch.resp_count  = o_count_r;
  assign out_ch.resp_last   = o_last_r;
  assign out_ch.accepted    = o_ok_r;
  assign out_ch.record_sent = o_sent_r;

  a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> state_r == t4t_pkg::PK_IDLE)
    else $error("job issued while sequencer busy");

  a_fetch_then_payload: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == t4t_pkg::PK_FETCH |=> state_r == t4t_pkg::PK_PAYLOAD)
    else $error("fetch not followed by payload byte");

  a_sent_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> !(o_sent_r && !o_ok_r))
    else $error("record_sent on a failed response");

  a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && need_push) |-> slot_free)
    else $error("result register overwritten");

  a_cc_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == t4t_pkg::PK_PAYLOAD && kind_r == t4t_pkg::SRC_CC)
      |-> ptr_r < 8'(t4t_pkg::CC_BYTES))
    else $error("capability file index out of range");

endmodule

// ===== hdl/type4_tag_ndef_responder.sv =====
// top level of the type 4 tag responder: matcher, response sequencer, config
// depends on t4t_pkg, t4t_channels, t4t_matcher, t4t_packer
//
//   channel  dir  payload                                            transaction
//   in_ch    in   action, record_index, data_byte, cmd_last          load or command byte
//   out_ch   out  resp_bytes, resp_count, resp_last, accepted,       one response word
//                 record_sent
//   cfg_ch   in   record_length                                      register write
//
// load and non-final command bytes pass while matcher and sequencer are idle; a final
// byte adds a decision step, then a fetch (record store read) and a payload state per
// payload byte, then the status bytes; in_ch.ready stays low until the sequencer is idle
// sync active-low reset clears control only; the record store is undefined until loaded
// the sequencer waits on out_ch only when a full or final word needs the result register
module type4_tag_ndef_responder (
  input  logic       clk,
  input  logic       rst_n,
  t4t_in_if.sink     in_ch,
  t4t_out_if.source  out_ch,
  t4t_cfg_if.sink    cfg_ch
);

  logic [7:0]        rec_len_r;
  logic              in_fire;
  logic              cmd_fire;
  logic              load_fire;
  logic              m_busy;
  logic              pk_idle;
  logic              job_valid;
  t4t_pkg::t4t_job_t job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_len_r <= 8'd0;
    end else if (cfg_ch.valid) begin
      rec_len_r <= cfg_ch.record_length;
    end
  end

  assign in_ch.ready = pk_idle && !m_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd_fire    = in_fire && (in_ch.action == t4t_pkg::ACT_CMD);
  assign load_fire   = in_fire && (in_ch.action == t4t_pkg::ACT_LOAD);

  t4t_matcher u_matcher (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (cmd_fire),
    .data_byte     (in_ch.data_byte),
    .cmd_last      (in_ch.cmd_last),
    .record_length (rec_len_r),
    .busy          (m_busy),
    .job_valid     (job_valid),
    .job           (job)
  );

  t4t_packer u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job           (job),
    .record_length (rec_len_r),
    .wr_en         (load_fire),
    .wr_addr       (in_ch.record_index),
    .wr_data       (in_ch.data_byte),
    .idle          (pk_idle),
    .out_ch        (out_ch)
  );

endmodule
